[sv/dds_pkg.sv]
// Shared types, constants and tables for the date day-shift pipeline.
`default_nettype none

package dds_pkg;

	localparam int unsigned DATE_W  = 22;	// day numbers stay below 2^22
	localparam int unsigned SHIFT_W = 20;
	localparam int unsigned JY_W    = 14;	// internal year count on the way back

	localparam logic [DATE_W-1:0] JD_BASE        = 22'd1720995;
	localparam logic [DATE_W-1:0] JD_REFORM      = 22'd2299161;
	localparam logic [DATE_W-1:0] JD_GREG_ORIGIN = 22'd1867216;
	localparam logic [DATE_W-1:0] DATE_PAD       = 22'd1524;
	// 2 - c + c/4 with c = jy/100 is -13 for every forward year (1984..2084)
	localparam logic [DATE_W-1:0] CENT_CORR      = 22'd13;
	// 100*(date - anchor) + 6680*36525 - 12210 reduces to 100*date - 12210
	localparam logic [28:0]       JY_OFFS        = 29'd12210;
	localparam logic [JY_W-1:0]   YEAR_BIAS      = 14'd4715;

	// reciprocals, exact for the numerator widths used
	localparam int unsigned GREG_SH = 41;
	localparam logic [63:0] GREG_DIV = 64'd146097;
	localparam logic [63:0] GREG_RECIP = ((64'd1 << GREG_SH) + GREG_DIV - 64'd1) / GREG_DIV;
	localparam logic [23:0] GREG_M = GREG_RECIP[23:0];

	localparam int unsigned YEAR_SH = 45;
	localparam logic [63:0] YEAR_DIV = 64'd36525;
	localparam logic [63:0] YEAR_RECIP = ((64'd1 << YEAR_SH) + YEAR_DIV - 64'd1) / YEAR_DIV;
	localparam logic [29:0] YEAR_M = YEAR_RECIP[29:0];

	localparam int unsigned CENT_SH = 19;
	localparam logic [63:0] CENT_DIV = 64'd100;
	localparam logic [63:0] CENT_RECIP = ((64'd1 << CENT_SH) + CENT_DIV - 64'd1) / CENT_DIV;
	localparam logic [12:0] CENT_M = CENT_RECIP[12:0];

	typedef struct packed {
		logic              ok;
		logic [DATE_W-1:0] date;
	} dds_jdn_t;

	typedef struct packed {
		logic              ok;
		logic [DATE_W-1:0] date;
		logic [JY_W-1:0]   jy;
	} dds_jy_t;

	// floor(30.6001 * k)
	function automatic logic [8:0] mon_days(input logic [3:0] k);
		logic [8:0] r;
		case (k)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd30;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd91;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd183;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd244;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd336;
			4'd12:   r = 9'd367;
			4'd13:   r = 9'd397;
			4'd14:   r = 9'd428;
			4'd15:   r = 9'd459;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[sv/dds_to_jdn.sv]
// Stage 1: range check and calendar date to shifted Julian day number.
`default_nettype none

module dds_to_jdn (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [dds_pkg::SHIFT_W-1:0] day_shift,
	input  wire logic                                i_valid,
	output logic                                     i_ready,
	input  wire logic [4:0]                          day,
	input  wire logic [3:0]                          month,
	input  wire logic [6:0]                          year_two_digit,
	output logic                                     o_valid,
	input  wire logic                                o_ready,
	output dds_pkg::dds_jdn_t                        o_data
);
	import dds_pkg::*;

	logic              valid_s1;
	logic              ok_s1;
	logic [DATE_W-1:0] date_s1;
	logic              en_s1;

	logic              ok;
	logic [11:0]       year;
	logic [11:0]       jy;
	logic [3:0]        jm;
	logic [DATE_W-1:0] base;
	logic signed [DATE_W:0] shifted;

	assign en_s1   = !valid_s1 || o_ready;
	assign i_ready = en_s1;

	always_comb begin
		ok   = (day != 5'd0) && (month != 4'd0) && (month <= 4'd12);
		year = 12'(year_two_digit) + ((year_two_digit < 7'd85) ? 12'd2000 : 12'd1900);
		// Jan and Feb count as months 13 and 14 of the year before
		if (month > 4'd2) begin
			jy = year;
			jm = month + 4'd1;
		end else begin
			jy = year - 12'd1;
			jm = month + 4'd13;
		end
		base = 22'(jy) * 22'd365 + 22'(jy >> 2) + 22'(mon_days(jm)) + 22'(day)
			+ JD_BASE - CENT_CORR;
		shifted = $signed({1'b0, base}) + $signed({{(DATE_W+1-SHIFT_W){day_shift[SHIFT_W-1]}},
			day_shift});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= i_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ok_s1   <= ok;
			date_s1 <= shifted[DATE_W-1:0];
		end
	end

	assign o_valid = valid_s1;
	assign o_data  = '{ok: ok_s1, date: date_s1};

endmodule

`default_nettype wire

[sv/dds_year.sv]
// Stages 2-4: Gregorian correction and year count from the day number.
`default_nettype none

module dds_year (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              i_valid,
	output logic                   i_ready,
	input  wire dds_pkg::dds_jdn_t i_data,
	output logic                   o_valid,
	input  wire logic              o_ready,
	output dds_pkg::dds_jy_t       o_data
);
	import dds_pkg::*;

	logic valid_s2, valid_s3, valid_s4;
	logic en_s2, en_s3, en_s4;

	logic              ok_s2, ok_s3, ok_s4;
	logic [DATE_W-1:0] date_s2, date_s3, date_s4;
	logic              greg_s2;
	logic [4:0]        gcorr_s2;
	logic [28:0]       njy_s3;
	logic [JY_W-1:0]   jy_s4;

	logic [20:0]       u;
	logic [22:0]       n;
	logic [46:0]       p_greg;
	logic [DATE_W-1:0] corr;
	logic [DATE_W-1:0] date3;
	logic [58:0]       p_year;

	assign en_s4   = !valid_s4 || o_ready;
	assign en_s3   = !valid_s3 || en_s4;
	assign en_s2   = !valid_s2 || en_s3;
	assign i_ready = en_s2;

	always_comb begin
		// stage 2: centuries skipped since the origin, (4u - 1) / 146097
		u      = 21'(i_data.date - JD_GREG_ORIGIN);
		n      = {u, 2'b00} - 23'd1;
		p_greg = 47'(n) * 47'(GREG_M);
		// stage 3
		corr   = greg_s2 ? (22'd1 + 22'(gcorr_s2) - 22'(gcorr_s2 >> 2)) : '0;
		date3  = date_s2 + corr + DATE_PAD;
		// stage 4: (100*date - 12210) / 36525
		p_year = 59'(njy_s3) * 59'(YEAR_M);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= i_valid;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ok_s2    <= i_data.ok;
			date_s2  <= i_data.date;
			greg_s2  <= (i_data.date >= JD_REFORM);
			gcorr_s2 <= p_greg[GREG_SH+4:GREG_SH];
		end
		if (en_s3) begin
			ok_s3   <= ok_s2;
			date_s3 <= date3;
			njy_s3  <= 29'(date3) * 29'd100 - JY_OFFS;
		end
		if (en_s4) begin
			ok_s4   <= ok_s3;
			date_s4 <= date_s3;
			jy_s4   <= p_year[YEAR_SH+JY_W-1:YEAR_SH];
		end
	end

	assign o_valid = valid_s4;
	assign o_data  = '{ok: ok_s4, date: date_s4, jy: jy_s4};

endmodule

`default_nettype wire

[sv/dds_to_date.sv]
// Stages 5-8: day of year, month split and two-digit year of the result.
`default_nettype none

module dds_to_date (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             i_valid,
	output logic                  i_ready,
	input  wire dds_pkg::dds_jy_t i_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [4:0]            out_day,
	output logic [3:0]            out_month,
	output logic [6:0]            out_year_two_digit,
	output logic                  valid_res
);
	import dds_pkg::*;

	logic valid_s5, valid_s6, valid_s7, valid_s8;
	logic en_s5, en_s6, en_s7, en_s8;

	logic              ok_s5, ok_s6, ok_s7;
	logic [8:0]        x_s5;
	logic [JY_W-1:0]   jy_s5;
	logic [4:0]        od_s6, od_s7;
	logic [3:0]        om_s6, om_s7;
	logic [11:0]       oy_s6, oy_s7;
	logic [5:0]        q_s7;
	logic [4:0]        day_s8;
	logic [3:0]        month_s8;
	logic [6:0]        year_s8;
	logic              ok_s8;

	logic [DATE_W-1:0] jd;
	logic [DATE_W-1:0] rem;
	logic [3:0]        jm;
	logic [3:0]        om;
	logic [JY_W-1:0]   oy;
	logic [24:0]       p_cent;
	logic [11:0]       yr;

	assign en_s8   = !valid_s8 || out_ready;
	assign en_s7   = !valid_s7 || en_s8;
	assign en_s6   = !valid_s6 || en_s7;
	assign en_s5   = !valid_s5 || en_s6;
	assign i_ready = en_s5;

	always_comb begin
		// stage 5: days left after the whole years
		jd  = 22'(i_data.jy) * 22'd365 + 22'(i_data.jy >> 2);
		rem = i_data.date - jd;
		// stage 6: month index is the largest k with x > floor(30.6001 k)
		jm = '0;
		for (int k = 1; k < 16; k++) begin
			if (x_s5 > mon_days(4'(k))) begin
				jm = 4'(k);
			end
		end
		om = (jm > 4'd13) ? (jm - 4'd13) : (jm - 4'd1);
		oy = jy_s5 - YEAR_BIAS - ((om > 4'd2) ? 14'd1 : 14'd0);
		// stage 7: year / 100
		p_cent = 25'(oy_s6) * 25'(CENT_M);
		// stage 8: year mod 100
		yr = oy_s7 - 12'(q_s7) * 12'd100;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			if (en_s5) begin
				valid_s5 <= i_valid;
			end
			if (en_s6) begin
				valid_s6 <= valid_s5;
			end
			if (en_s7) begin
				valid_s7 <= valid_s6;
			end
			if (en_s8) begin
				valid_s8 <= valid_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ok_s5 <= i_data.ok;
			x_s5  <= rem[8:0];
			jy_s5 <= i_data.jy;
		end
		if (en_s6) begin
			ok_s6 <= ok_s5;
			od_s6 <= 5'(x_s5 - mon_days(jm));
			om_s6 <= om;
			oy_s6 <= oy[11:0];
		end
		if (en_s7) begin
			ok_s7 <= ok_s6;
			od_s7 <= od_s6;
			om_s7 <= om_s6;
			oy_s7 <= oy_s6;
			q_s7  <= p_cent[CENT_SH+5:CENT_SH];
		end
		if (en_s8) begin
			ok_s8    <= ok_s7;
			day_s8   <= ok_s7 ? od_s7 : '0;
			month_s8 <= ok_s7 ? om_s7 : '0;
			year_s8  <= ok_s7 ? yr[6:0] : '0;
		end
	end

	assign out_valid          = valid_s8;
	assign out_day            = day_s8;
	assign out_month          = month_s8;
	assign out_year_two_digit = year_s8;
	assign valid_res          = ok_s8;

endmodule

`default_nettype wire

[sv/date_day_shift_top.sv]
// Top level of the date day-shift pipeline with its shift register.
//
// Takes a date as day, month and two-digit year (85-99 read as 1985-1999,
// 00-84 as 2000-2084, 100-127 as 2000-2027), moves it by the signed day
// count held in the day_shift register and returns the new day, month and
// year modulo 100. The date passes through a Julian day number with the
// Gregorian correction; results that land before the 1582 reform come back
// in the Julian calendar. Only 1..31 is checked for the day, so 31.02 rolls
// into March; a day of 0 or a month outside 1..12 returns valid_res = 0 with
// all date fields zero. The pipeline has eight register stages: one request
// enters every cycle while nothing stalls, and its result shows on the out
// channel from the last of them. The depth is set by the chain of constant
// reciprocal multiplies (century count, year count, year modulo 100), each
// followed by a register. Back-pressure on out_ready stops only the stages
// that hold data, so empty stages keep filling. cfg_ready is always high;
// a write to day_shift (20-bit two's complement, reset 0) applies to every
// request accepted afterwards and must only happen with the pipeline empty.
`default_nettype none

module date_day_shift_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [dds_pkg::SHIFT_W-1:0] cfg_data,
	// input requests
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [4:0]                  day,
	input  wire logic [3:0]                  month,
	input  wire logic [6:0]                  year_two_digit,
	// results
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [4:0]                       out_day,
	output logic [3:0]                       out_month,
	output logic [6:0]                       out_year_two_digit,
	output logic                             valid_res
);
	import dds_pkg::*;

	logic signed [SHIFT_W-1:0] day_shift_q;

	// hand-off between the three pipeline segments
	logic     jdn_valid, jdn_ready;
	dds_jdn_t jdn_data;
	logic     jy_valid, jy_ready;
	dds_jy_t  jy_data;

	// the register is a plain write port, never busy
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_shift_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			day_shift_q <= $signed(cfg_data);
		end
	end

	// stage 1: checks, calendar date to day number, add the shift
	dds_to_jdn u_to_jdn (
		.clk            (clk),
		.arst_n         (arst_n),
		.day_shift      (day_shift_q),
		.i_valid        (in_valid),
		.i_ready        (in_ready),
		.day            (day),
		.month          (month),
		.year_two_digit (year_two_digit),
		.o_valid        (jdn_valid),
		.o_ready        (jdn_ready),
		.o_data         (jdn_data)
	);

	// stages 2-4: Gregorian correction and year count
	dds_year u_year (
		.clk     (clk),
		.arst_n  (arst_n),
		.i_valid (jdn_valid),
		.i_ready (jdn_ready),
		.i_data  (jdn_data),
		.o_valid (jy_valid),
		.o_ready (jy_ready),
		.o_data  (jy_data)
	);

	// stages 5-8: month and day split, year modulo 100, output register
	dds_to_date u_to_date (
		.clk                (clk),
		.arst_n             (arst_n),
		.i_valid            (jy_valid),
		.i_ready            (jy_ready),
		.i_data             (jy_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.out_day            (out_day),
		.out_month          (out_month),
		.out_year_two_digit (out_year_two_digit),
		.valid_res          (valid_res)
	);

endmodule

`default_nettype wire
